// ===== hdl/mfd_pkg.sv =====
// Shared constants, types and codes of the marked frame deframer.
`default_nettype none
package mfd_pkg;

    localparam int DEPTH     = 4096;
    localparam int AW        = $clog2(DEPTH);
    localparam int LW        = AW + 1;
    localparam int OVERHEAD  = 24;
    localparam int MARKERS   = 2;
    localparam int MIN_FRAME = OVERHEAD + MARKERS;
    localparam int EW        = 8;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);
    localparam int IN_W      = 24;
    localparam int OUT_W     = 120;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WALK  = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;

    typedef struct packed {
        logic [1:0]    kind;
        logic [AW-1:0] addr;
        logic [7:0]    data;
        logic [LW-1:0] len;
    } t_op;

    typedef struct packed {
        logic room2;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

// ===== hdl/mfd_queue.sv =====
// Small in-order operation queue between the front and back parts.
`default_nettype none
module mfd_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  mfd_pkg::t_op      i_op,
    input  wire               i_pop,
    output mfd_pkg::t_op      o_op,
    output mfd_pkg::t_qstat   o_qstat
);

    mfd_pkg::t_op                r_mem [0:mfd_pkg::QDEPTH-1];
    logic [mfd_pkg::QAW-1:0]     r_wr;
    logic [mfd_pkg::QAW-1:0]     r_rd;
    logic [mfd_pkg::QAW:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_op          = r_mem[r_rd];
    assign o_qstat.empty = (r_cnt == '0);
    assign o_qstat.room2 = (r_cnt <= (mfd_pkg::QAW+1)'(mfd_pkg::QDEPTH - 2));

endmodule
`default_nettype wire

// ===== hdl/mfd_front.sv =====
// Front part: accepts items, tracks the ring position and fill, keeps the end claims.
`default_nettype none
module mfd_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire  [7:0]        i_start_marker,
    input  wire  [7:0]        i_end_marker,
    input  wire               i_s_tvalid,
    output logic              o_s_tready,
    input  wire  [mfd_pkg::IN_W-1:0] i_s_tdata,
    input  mfd_pkg::t_qstat   i_qstat,
    output logic              o_q_push,
    output mfd_pkg::t_op      o_q_op
);

    localparam int AW = mfd_pkg::AW;
    localparam int LW = mfd_pkg::LW;
    localparam int EW = mfd_pkg::EW;
    localparam int CW = EW + LW;

    localparam logic [1:0] F_IDLE  = 2'd0;
    localparam logic [1:0] F_CLAIM = 2'd1;
    localparam logic [1:0] F_CCHK  = 2'd2;
    localparam logic [1:0] F_CLR   = 2'd3;

    logic [1:0]        r_state, n_state;
    logic [AW-1:0]     r_wp, n_wp;
    logic [AW-1:0]     r_p, n_p;
    logic [LW-1:0]     r_fill, n_fill;
    logic [4:0][7:0]   r_hist, n_hist;
    logic [EW-1:0]     r_epoch, n_epoch;
    logic [AW-1:0]     r_clr, n_clr;
    logic [LW-1:0]     r_len, n_len;
    logic [AW-1:0]     r_e, n_e;

    // Claim memory: epoch mark and claimed length per end address.
    logic [CW-1:0]     r_claims [0:mfd_pkg::DEPTH-1];
    logic [CW-1:0]     r_crd;
    logic              w_we, w_re;
    logic [AW-1:0]     w_wa, w_ra;
    logic [CW-1:0]     w_wd;

    logic              w_acc;
    logic              w_mode;
    logic [7:0]        w_data;
    logic [AW-1:0]     w_addr;
    logic [EW-1:0]     w_cep;
    logic [LW-1:0]     w_clen;
    logic              w_cvalid;
    logic [31:0]       w_len32;
    logic [LW:0]       w_limit;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_claims[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_crd <= r_claims[w_ra];
        end
    end

    assign o_s_tready = (r_state == F_IDLE) && i_qstat.room2;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_mode     = i_s_tdata[0];
    assign w_data     = i_s_tdata[8:1];
    assign w_addr     = i_s_tdata[20:9];
    assign w_cep      = r_crd[CW-1:LW];
    assign w_clen     = r_crd[LW-1:0];
    assign w_cvalid   = (w_cep == r_epoch) && (w_clen != '0);
    assign w_len32    = {r_hist[3], r_hist[2], r_hist[1], r_hist[0]};
    assign w_limit    = {1'b0, r_fill} + {1'b0, r_len} - (LW+1)'(5);

    always_comb begin
        n_state  = r_state;
        n_wp     = r_wp;
        n_p      = r_p;
        n_fill   = r_fill;
        n_hist   = r_hist;
        n_epoch  = r_epoch;
        n_clr    = r_clr;
        n_len    = r_len;
        n_e      = r_e;
        w_we     = 1'b0;
        w_wa     = r_p;
        w_wd     = '0;
        w_re     = 1'b0;
        w_ra     = r_wp;
        o_q_push = 1'b0;
        o_q_op   = '0;
        case (r_state)
            F_IDLE: begin
                if (w_acc) begin
                    o_q_push = 1'b1;
                    if (w_mode) begin
                        o_q_op.kind = mfd_pkg::OP_READ;
                        o_q_op.addr = w_addr;
                    end else begin
                        o_q_op.kind = mfd_pkg::OP_WRITE;
                        o_q_op.addr = r_wp;
                        o_q_op.data = w_data;
                        n_p    = r_wp;
                        n_wp   = r_wp + 1'b1;
                        if (r_fill < LW'(mfd_pkg::DEPTH)) begin
                            n_fill = r_fill + 1'b1;
                        end
                        n_hist = {r_hist[3:0], w_data};
                        w_re   = 1'b1;
                        w_ra   = r_wp;
                        n_state = F_CLAIM;
                    end
                end
            end
            F_CLAIM: begin
                if (w_cvalid && (r_hist[0] == i_end_marker) && (w_clen <= r_fill)) begin
                    // Frame closes here: hand it to the walker, drop all claims.
                    o_q_push    = 1'b1;
                    o_q_op.kind = mfd_pkg::OP_WALK;
                    o_q_op.addr = r_p - (w_clen[AW-1:0] - 1'b1);
                    o_q_op.len  = w_clen;
                    n_epoch     = r_epoch + 1'b1;
                    n_fill      = '0;
                    n_state     = (r_epoch == '1) ? F_CLR : F_IDLE;
                end else begin
                    w_we = 1'b1;
                    w_wa = r_p;
                    w_wd = '0;
                    if ((r_fill >= LW'(5)) && (r_hist[4] == i_start_marker) &&
                        (w_len32 >= 32'(mfd_pkg::MIN_FRAME)) &&
                        (w_len32 <= 32'(mfd_pkg::DEPTH))) begin
                        n_len   = w_len32[LW-1:0];
                        n_e     = r_p + w_len32[AW-1:0] - AW'(5);
                        w_re    = 1'b1;
                        w_ra    = n_e;
                        n_state = F_CCHK;
                    end else begin
                        n_state = F_IDLE;
                    end
                end
            end
            F_CCHK: begin
                // An earlier claim on the same end wins while its start is held.
                if (!w_cvalid || ({1'b0, w_clen} > w_limit)) begin
                    w_we = 1'b1;
                    w_wa = r_e;
                    w_wd = {r_epoch, r_len};
                end
                n_state = F_IDLE;
            end
            F_CLR: begin
                w_we  = 1'b1;
                w_wa  = r_clr;
                w_wd  = '0;
                n_clr = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_CLR;
            r_wp    <= '0;
            r_fill  <= '0;
            r_epoch <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_fill  <= n_fill;
            r_epoch <= n_epoch;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p    <= n_p;
        r_hist <= n_hist;
        r_len  <= n_len;
        r_e    <= n_e;
    end

endmodule
`default_nettype wire

// ===== hdl/mfd_back.sv =====
// Back part: byte store, read requests and the frame field walker.
`default_nettype none
module mfd_back (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  mfd_pkg::t_qstat            i_qstat,
    input  mfd_pkg::t_op               i_q_op,
    output logic                       o_q_pop,
    output logic                       o_m_tvalid,
    input  wire                        i_m_tready,
    output logic [mfd_pkg::OUT_W-1:0]  o_m_tdata
);

    localparam int AW = mfd_pkg::AW;
    localparam int LW = mfd_pkg::LW;

    localparam logic [3:0] B_IDLE  = 4'd0;
    localparam logic [3:0] B_RRES  = 4'd1;
    localparam logic [3:0] B_CHK   = 4'd2;
    localparam logic [3:0] B_FETCH = 4'd3;
    localparam logic [3:0] B_SHIFT = 4'd4;
    localparam logic [3:0] B_FIELD = 4'd5;
    localparam logic [3:0] B_SUM   = 4'd6;
    localparam logic [3:0] B_FIN   = 4'd7;
    localparam logic [3:0] B_BAD   = 4'd8;

    logic [7:0]    r_store [0:mfd_pkg::DEPTH-1];
    logic [7:0]    r_srd;
    logic          w_we, w_re;
    logic [AW-1:0] w_wa, w_ra;
    logic [7:0]    w_wd;

    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_s, n_s;
    logic [LW-1:0] r_len, n_len;
    logic [31:0]   r_off, n_off;
    logic [1:0]    r_k, n_k;
    logic [1:0]    r_fi, n_fi;
    logic [31:0]   r_word, n_word;
    logic [LW-1:0] r_idl, n_idl;
    logic [LW-1:0] r_ml, n_ml;
    logic [31:0]   r_ec, n_ec;
    logic [30:0]   r_il, n_il;
    logic [31:0]   r_used, n_used;
    logic          r_ovalid, n_ovalid;
    logic [mfd_pkg::OUT_W-1:0] r_odata, n_odata;
    logic          w_free;
    logic [31:0]   w_pay;

    function automatic logic [mfd_pkg::OUT_W-1:0] pack_res(
        input logic [1:0]    st,
        input logic [AW-1:0] fs,
        input logic [LW-1:0] fl,
        input logic [LW-1:0] il_id,
        input logic [LW-1:0] il_m,
        input logic [31:0]   ec,
        input logic [LW-1:0] il_i,
        input logic [LW-1:0] pl,
        input logic [7:0]    rb
    );
        return {1'b0, rb, pl, il_i, ec, il_m, il_id, fl, fs, st};
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_srd <= r_store[w_ra];
        end
    end

    assign w_free     = !r_ovalid || i_m_tready;
    assign w_pay      = {19'b0, r_len} - r_used;
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_len    = r_len;
        n_off    = r_off;
        n_k      = r_k;
        n_fi     = r_fi;
        n_word   = r_word;
        n_idl    = r_idl;
        n_ml     = r_ml;
        n_ec     = r_ec;
        n_il     = r_il;
        n_used   = r_used;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata  = r_odata;
        w_we     = 1'b0;
        w_wa     = i_q_op.addr;
        w_wd     = i_q_op.data;
        w_re     = 1'b0;
        w_ra     = i_q_op.addr;
        o_q_pop  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) begin
                    o_q_pop = 1'b1;
                    case (i_q_op.kind)
                        mfd_pkg::OP_WRITE: begin
                            w_we = 1'b1;
                        end
                        mfd_pkg::OP_READ: begin
                            w_re    = 1'b1;
                            n_state = B_RRES;
                        end
                        mfd_pkg::OP_WALK: begin
                            n_s     = i_q_op.addr;
                            n_len   = i_q_op.len;
                            n_off   = 32'd5;
                            n_fi    = 2'd0;
                            n_state = B_CHK;
                        end
                        default: begin
                            n_state = B_IDLE;
                        end
                    endcase
                end
            end
            B_RRES: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = pack_res(mfd_pkg::ST_READ, '0, '0, '0, '0, '0, '0, '0, r_srd);
                    n_state  = B_IDLE;
                end
            end
            B_CHK: begin
                // A four-byte field must end before the end byte.
                if (({1'b0, r_off} + 33'd4) > ({20'b0, r_len} - 33'd1)) begin
                    n_state = B_BAD;
                end else begin
                    n_k     = 2'd0;
                    n_state = B_FETCH;
                end
            end
            B_FETCH: begin
                w_re    = 1'b1;
                w_ra    = r_s + r_off[AW-1:0] + AW'(r_k);
                n_state = B_SHIFT;
            end
            B_SHIFT: begin
                n_word  = {r_word[23:0], r_srd};
                n_k     = r_k + 1'b1;
                n_state = (r_k == 2'd3) ? B_FIELD : B_FETCH;
            end
            B_FIELD: begin
                case (r_fi)
                    2'd0: begin
                        if (r_word[31]) begin
                            n_state = B_BAD;
                        end else begin
                            n_idl   = r_word[LW-1:0];
                            n_off   = r_off + 32'd4 + r_word;
                            n_fi    = 2'd1;
                            n_state = B_CHK;
                        end
                    end
                    2'd1: begin
                        if (r_word[31]) begin
                            n_state = B_BAD;
                        end else begin
                            n_ml    = r_word[LW-1:0];
                            n_off   = r_off + 32'd4 + r_word;
                            n_fi    = 2'd2;
                            n_state = B_CHK;
                        end
                    end
                    2'd2: begin
                        n_ec    = r_word;
                        n_off   = r_off + 32'd4;
                        n_fi    = 2'd3;
                        n_state = B_CHK;
                    end
                    default: begin
                        if (r_word[31]) begin
                            n_state = B_BAD;
                        end else begin
                            n_il    = r_word[30:0];
                            n_state = B_SUM;
                        end
                    end
                endcase
            end
            B_SUM: begin
                n_used  = {19'b0, r_idl} + {19'b0, r_ml} + {1'b0, r_il} +
                          32'(mfd_pkg::MIN_FRAME);
                n_state = B_FIN;
            end
            B_FIN: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    if (r_used > {19'b0, r_len}) begin
                        n_odata = pack_res(mfd_pkg::ST_BAD, r_s, r_len,
                                           '0, '0, '0, '0, '0, '0);
                    end else begin
                        n_odata = pack_res(mfd_pkg::ST_OK, r_s, r_len, r_idl, r_ml,
                                           r_ec, r_il[LW-1:0], w_pay[LW-1:0], '0);
                    end
                    n_state = B_IDLE;
                end
            end
            B_BAD: begin
                if (w_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = pack_res(mfd_pkg::ST_BAD, r_s, r_len,
                                        '0, '0, '0, '0, '0, '0);
                    n_state  = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s     <= n_s;
        r_len   <= n_len;
        r_off   <= n_off;
        r_k     <= n_k;
        r_fi    <= n_fi;
        r_word  <= n_word;
        r_idl   <= n_idl;
        r_ml    <= n_ml;
        r_ec    <= n_ec;
        r_il    <= n_il;
        r_used  <= n_used;
        r_odata <= n_odata;
    end

endmodule
`default_nettype wire

// ===== hdl/marked_frame_deframer.sv =====
// Top level of the marked frame deframer: configuration registers and the two parts.
//
// Input channel (i_s_*): each item is a push of one stream byte (mode 0) or a
// read of one stored byte by address (mode 1). Output channel (o_m_*): one item
// per read, and one per closed frame, either accepted with its field lengths
// and error code or marked malformed with its start address and length.
// A frame opens with the start marker and a big-endian 32-bit length; it is
// closed when the end marker lands on the position that the length claims.
// The front part handles a push through its claim state, and through a claim check
// state when a new claim forms (claim memory read, then a second read and write);
// a read stays in the idle state. The back part writes the store from its idle
// state, answers a read from a result state, and walks a closed frame field by
// field: a bound check, then four store byte fetches, each followed by a shift,
// then the field step. A four-entry queue between the parts lets pushes continue
// while a walk runs. After reset the claim memory is cleared with tready low;
// the same clearing pass runs after every 256th closed frame. Configuration
// writes take effect at the next edge and belong where no item is in flight.
// When the receiver stalls, the result is held in the output register, the
// back part waits, the queue fills and tready falls once the queue has fewer
// than two free entries.
`default_nettype none
module marked_frame_deframer (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // Configuration write port.
    input  wire         i_cfg_we,
    input  wire  [1:0]  i_cfg_idx,
    input  wire  [7:0]  i_cfg_data,
    // tdata from bit 0: mode[0], data_byte[8:1], read_addr[20:9], zero fill.
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [23:0] i_s_tdata,
    // tdata from bit 0: status[1:0], frame_start[13:2], frame_len[26:14],
    // id_len[39:27], method_len[52:40], error_code[84:53], info_len[97:85],
    // payload_len[110:98], read_byte[118:111], zero fill.
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [119:0] o_m_tdata
);

    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;

    logic [7:0]        r_start_marker;
    logic [7:0]        r_end_marker;
    mfd_pkg::t_qstat   w_qstat;
    mfd_pkg::t_op      w_push_op;
    mfd_pkg::t_op      w_head_op;
    logic              w_push;
    logic              w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= 8'd2;
            r_end_marker   <= 8'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START: r_start_marker <= i_cfg_data;
                CFG_END:   r_end_marker   <= i_cfg_data;
                default:   r_start_marker <= r_start_marker;
            endcase
        end
    end

    mfd_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_marker (r_start_marker),
        .i_end_marker   (r_end_marker),
        .i_s_tvalid     (i_s_tvalid),
        .o_s_tready     (o_s_tready),
        .i_s_tdata      (i_s_tdata),
        .i_qstat        (w_qstat),
        .o_q_push       (w_push),
        .o_q_op         (w_push_op)
    );

    mfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_op    (w_push_op),
        .i_pop   (w_pop),
        .o_op    (w_head_op),
        .o_qstat (w_qstat)
    );

    mfd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (w_qstat),
        .i_q_op     (w_head_op),
        .o_q_pop    (w_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire

// ===== hdl/mfd_checker.sv =====
// Port-level checks of the marked frame deframer and their bind.
`default_nettype none
module mfd_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [119:0] o_m_tdata
);

    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[1:0] == mfd_pkg::ST_OK) ||
                       (o_m_tdata[1:0] == mfd_pkg::ST_BAD) ||
                       (o_m_tdata[1:0] == mfd_pkg::ST_READ))
        else $error("unknown status");

    a_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == mfd_pkg::ST_READ) |-> o_m_tdata[110:2] == '0)
        else $error("read result carries frame fields");

    a_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[1:0] == mfd_pkg::ST_BAD) |-> o_m_tdata[119:27] == '0)
        else $error("malformed result carries field data");

endmodule

bind marked_frame_deframer mfd_checker u_mfd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench of the marked frame deframer: random byte streams, frames and reads.
`default_nettype none
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // Configuration register indexes.
    localparam logic [1:0] REG_START_MARK = 2'd0;
    localparam logic [1:0] REG_END_MARK   = 2'd1;

    localparam bit MODE_PUSH  = 1'b0;
    localparam bit MODE_READ  = 1'b1;
    localparam int TARGET     = 1450;
    localparam int DIRECTED   = 200;
    localparam int CYCLE_CAP  = 1000000;
    localparam int SETTLE     = 80;
    localparam int DEPTH      = mfd_pkg::DEPTH;
    localparam int MIN_FRAME  = mfd_pkg::MIN_FRAME;

    // One input item as it travels in tdata.
    typedef struct {
        bit        mode;
        bit [7:0]  data;
        bit [11:0] addr;
    } t_req;

    // One output item, field by field.
    typedef struct {
        bit [1:0]  status;
        bit [11:0] fstart;
        bit [12:0] flen;
        bit [12:0] id_len;
        bit [12:0] method_len;
        bit [31:0] err_code;
        bit [12:0] info_len;
        bit [12:0] pay_len;
        bit [7:0]  rbyte;
    } t_resp;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_idx = '0;
    logic [7:0]   i_cfg_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [23:0]  i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [119:0] o_m_tdata;

    marked_frame_deframer u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Shadow of the block: byte ring, end claims, pointers and markers.
    bit [7:0]    ring_bytes [DEPTH];
    int unsigned ring_claims [DEPTH];
    int unsigned ring_wp, ring_fill;
    bit [7:0]    mark_start, mark_end;

    // Stimulus side: pending items and a record of written ring entries, so
    // that a read never targets an entry that was never filled.
    t_req        pending_items [$];
    t_resp       expected_resps [$];
    bit          gen_written [DEPTH];
    int unsigned gen_wp;
    int          gen_count;
    int          send_gap_max, recv_stall_max;
    int          errors;
    int          cycles = 0;

    function automatic bit [31:0] ring_be32(int unsigned pos);
        bit [31:0] v;
        v = 0;
        for (int k = 0; k < 4; k++) begin
            v = (v << 8) | ring_bytes[(pos + k) % DEPTH];
        end
        return v;
    endfunction

    // Walks a closed frame and builds its result.
    function automatic t_resp walk_frame(int unsigned s, int unsigned len);
        t_resp       r;
        longint      off, last_off, used;
        bit [31:0]   idl, ml, ec, il;
        r = '{default: 0};
        r.status = mfd_pkg::ST_BAD;
        r.fstart = s[11:0];
        r.flen   = len[12:0];
        off      = 5;
        last_off = longint'(len) - 1;
        if (off + 4 > last_off) return r;
        idl = ring_be32(32'((s + off) % DEPTH));
        if (idl[31]) return r;
        off += 4 + idl;
        if (off + 4 > last_off) return r;
        ml = ring_be32(32'((s + off) % DEPTH));
        if (ml[31]) return r;
        off += 4 + ml;
        if (off + 4 > last_off) return r;
        ec = ring_be32(32'((s + off) % DEPTH));
        off += 4;
        if (off + 4 > last_off) return r;
        il = ring_be32(32'((s + off) % DEPTH));
        if (il[31]) return r;
        used = longint'(idl) + ml + il + MIN_FRAME;
        if (used > len) return r;
        r.status     = mfd_pkg::ST_OK;
        r.id_len     = idl[12:0];
        r.method_len = ml[12:0];
        r.err_code   = ec;
        r.info_len   = il[12:0];
        r.pay_len    = 13'(longint'(len) - used);
        return r;
    endfunction

    // Applies one accepted item to the shadow and queues any result it causes.
    task automatic deframe_item(t_req q);
        t_resp       r;
        int unsigned p, claim, s, len, ahead, e, x;
        if (q.mode == MODE_READ) begin
            r = '{default: 0};
            r.status = mfd_pkg::ST_READ;
            r.rbyte  = ring_bytes[q.addr];
            expected_resps = {expected_resps, r};
            return;
        end
        p = ring_wp;
        // A full ring drops its oldest byte, so the fill stays at the depth.
        if (ring_fill < DEPTH) ring_fill++;
        ring_bytes[p] = q.data;
        ring_wp = (p + 1) % DEPTH;
        claim = ring_claims[p];
        ring_claims[p] = 0;
        if (claim != 0 && q.data == mark_end && claim <= ring_fill) begin
            s = (p + DEPTH - (claim - 1)) % DEPTH;
            r = walk_frame(s, claim);
            expected_resps = {expected_resps, r};
            ring_fill = 0;
            foreach (ring_claims[i]) ring_claims[i] = 0;
            return;
        end
        if (ring_fill >= 5 && ring_bytes[(p + DEPTH - 4) % DEPTH] == mark_start) begin
            len = ring_be32((p + DEPTH - 3) % DEPTH);
            if (len >= MIN_FRAME && len <= DEPTH) begin
                ahead = len - 5;
                e = (p + ahead) % DEPTH;
                x = ring_claims[e];
                // An earlier claim on the same end wins while its start is held.
                if (x == 0 || longint'(x) > longint'(ring_fill) + ahead)
                    ring_claims[e] = len;
            end
        end
    endtask

    // Sender: feeds pending items with random gaps between them.
    int send_gap;
    always @(posedge i_clk) begin
        t_req q;
        int   g;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap   <= 0;
        end else if (i_s_tvalid && o_s_tready) begin
            deframe_item('{mode: i_s_tdata[0], data: i_s_tdata[8:1],
                           addr: i_s_tdata[20:9]});
            g = $urandom_range(0, send_gap_max);
            if (g == 0 && pending_items.size() != 0) begin
                q = pending_items.pop_front();
                i_s_tdata <= {3'b0, q.addr, q.data, q.mode};
            end else begin
                i_s_tvalid <= 1'b0;
                send_gap   <= g;
            end
        end else if (!i_s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_items.size() != 0) begin
                q = pending_items.pop_front();
                i_s_tdata  <= {3'b0, q.addr, q.data, q.mode};
                i_s_tvalid <= 1'b1;
            end
        end
    end

    // Receiver: checks each result against the oldest expectation and stalls.
    int recv_stall;
    always @(posedge i_clk) begin
        t_resp a, x;
        int    st;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_stall <= 0;
        end else if (i_m_tready && o_m_tvalid) begin
            a.status     = o_m_tdata[1:0];
            a.fstart     = o_m_tdata[13:2];
            a.flen       = o_m_tdata[26:14];
            a.id_len     = o_m_tdata[39:27];
            a.method_len = o_m_tdata[52:40];
            a.err_code   = o_m_tdata[84:53];
            a.info_len   = o_m_tdata[97:85];
            a.pay_len    = o_m_tdata[110:98];
            a.rbyte      = o_m_tdata[118:111];
            if (expected_resps.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, actual %p", $realtime, a);
            end else begin
                x = expected_resps.pop_front();
                if (a.status != x.status || a.fstart != x.fstart || a.flen != x.flen ||
                    a.id_len != x.id_len || a.method_len != x.method_len ||
                    a.err_code != x.err_code || a.info_len != x.info_len ||
                    a.pay_len != x.pay_len || a.rbyte != x.rbyte) begin
                    errors++;
                    $display("%0t: mismatch, expected %p", $realtime, x);
                    $display("%0t: mismatch, actual   %p", $realtime, a);
                end
            end
            st = $urandom_range(0, recv_stall_max);
            if (st > 0) begin
                i_m_tready <= 1'b0;
                recv_stall <= st;
            end
        end else if (!i_m_tready) begin
            if (recv_stall <= 1) i_m_tready <= 1'b1;
            recv_stall <= recv_stall - 1;
        end
    end

    // Run limit; allows for the claim clearing pass after reset.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic push_byte(bit [7:0] b);
        t_req q;
        q = '{mode: MODE_PUSH, data: b, addr: 12'd0};
        pending_items = {pending_items, q};
        gen_written[gen_wp] = 1'b1;
        gen_wp = (gen_wp + 1) % DEPTH;
        gen_count++;
    endtask

    task automatic push_word(bit [31:0] w);
        for (int k = 3; k >= 0; k--) push_byte(w[8*k +: 8]);
    endtask

    // Reads a stored byte; only entries that have been filled are chosen.
    task automatic read_byte_at(bit [11:0] a);
        t_req q;
        if (!gen_written[a]) a = 12'((gen_wp + DEPTH - 1) % DEPTH);
        if (!gen_written[a]) return;
        q = '{mode: MODE_READ, data: 8'($urandom), addr: a};
        pending_items = {pending_items, q};
        gen_count++;
    endtask

    task automatic push_noise(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 7) == 0) push_byte(($urandom & 1) ? mark_start : mark_end);
            else push_byte(8'($urandom));
        end
    endtask

    // Frame flaws the generator can plant.
    typedef enum int {
        FL_NONE, FL_BAD_END, FL_ID_SIGN, FL_LEN_SKEW, FL_NEG_PAYLOAD, FL_TRUNCATED
    } t_flaw;

    // Pushes one frame: marker, length, id, method, error code, info, payload,
    // check word and end marker.
    task automatic push_frame(int idl, int ml, int il, int pl, t_flaw flaw);
        int        len;
        bit [31:0] idw, ilw, lenw;
        len  = MIN_FRAME + idl + ml + il + pl;
        lenw = len;
        idw  = idl;
        ilw  = il;
        case (flaw)
            FL_ID_SIGN:     idw[31] = 1'b1;
            FL_LEN_SKEW:    lenw = len + $urandom_range(1, 40) - 20;
            FL_NEG_PAYLOAD: ilw = il + pl + $urandom_range(1, 4);
            default: ;
        endcase
        push_byte(mark_start);
        push_word(lenw);
        push_word(idw);
        for (int i = 0; i < idl; i++) push_byte(8'($urandom));
        push_word(ml);
        for (int i = 0; i < ml; i++) push_byte(8'($urandom));
        push_word($urandom);
        push_word(ilw);
        for (int i = 0; i < il + pl; i++) push_byte(8'($urandom));
        if (flaw == FL_TRUNCATED) return;
        push_word($urandom);
        push_byte(flaw == FL_BAD_END ? mark_end ^ 8'($urandom_range(1, 255)) : mark_end);
    endtask

    task automatic random_frame();
        int big;
        big = ($urandom_range(0, 19) == 0);
        push_frame($urandom_range(0, big ? 120 : 6), $urandom_range(0, big ? 120 : 6),
                   $urandom_range(0, big ? 120 : 6), $urandom_range(0, big ? 200 : 10),
                   ($urandom_range(0, 3) == 0) ? t_flaw'($urandom_range(1, 5)) : FL_NONE);
    endtask

    // Waits until the block has returned everything and settled.
    task automatic drain();
        while (pending_items.size() != 0 || i_s_tvalid || expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, bit [7:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_START_MARK) mark_start = v;
        else mark_end = v;
        @(posedge i_clk);
    endtask

    // Random phase: mostly well-formed frames with random content, the rest
    // noise, broken frames, overlapping claims and reads.
    task automatic random_phase(int n);
        int stop, L;
        stop = gen_count + n;
        while (gen_count < stop) begin
            send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 17;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: random_frame();
                5: push_noise($urandom_range(1, 8));
                6, 7: for (int i = 0; i < 3; i++) read_byte_at(12'($urandom));
                8: begin
                    // A second start whose claim shares the frame's end.
                    L = $urandom_range(MIN_FRAME, 60);
                    push_byte(mark_start);
                    push_word(L + 5);
                    push_frame(0, 0, 0, L - MIN_FRAME, FL_NONE);
                end
                default: begin
                    push_frame($urandom_range(0, 4), 0, 0, $urandom_range(0, 4), FL_TRUNCATED);
                    push_noise($urandom_range(1, 6));
                end
            endcase
        end
    endtask

    initial begin
        ring_wp        = 0;
        ring_fill      = 0;
        mark_start     = 8'd2;
        mark_end       = 8'd3;
        gen_wp         = 0;
        gen_count      = 0;
        errors         = 0;
        send_gap_max   = 17;
        recv_stall_max = 17;
        foreach (ring_claims[i]) ring_claims[i] = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset markers: smallest frame, the walk's
        // failure cases, a claim too short to count, a wrong end byte, reads.
        push_frame(0, 0, 0, 0, FL_NONE);
        read_byte_at(12'd0);
        push_frame(2, 3, 1, 4, FL_NONE);
        push_frame(1, 0, 0, 0, FL_ID_SIGN);
        push_frame(0, 1, 1, 2, FL_NEG_PAYLOAD);
        push_frame(1, 1, 1, 1, FL_BAD_END);
        push_byte(mark_start);
        push_word(MIN_FRAME - 1);
        push_noise(22);
        push_frame(0, 0, 0, 1, FL_NONE);
        read_byte_at(12'd5);
        drain();

        write_reg(REG_START_MARK, 8'd0);
        write_reg(REG_END_MARK, 8'd255);
        random_phase((TARGET - DIRECTED) / 4);
        drain();

        write_reg(REG_START_MARK, 8'd255);
        write_reg(REG_END_MARK, 8'd0);
        random_phase((TARGET - DIRECTED) / 4);
        drain();

        write_reg(REG_START_MARK, 8'($urandom));
        write_reg(REG_END_MARK, 8'($urandom));
        if (mark_start == mark_end) write_reg(REG_END_MARK, mark_start ^ 8'h5A);
        random_phase((TARGET - DIRECTED) / 4);
        drain();

        write_reg(REG_START_MARK, 8'd2);
        write_reg(REG_END_MARK, 8'd3);
        random_phase((TARGET - DIRECTED) / 4);
        drain();

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
